// File: rtl/edc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edc_pkg: shared types and constants for epoch_to_calendar
// Controller states, divide phases, command/status bundles, calendar tables.
// ----------------------------------------------------------------------------
package edc_pkg;

  localparam int unsigned EpochW    = 32;  // input seconds
  localparam int unsigned DayW      = 16;  // whole days since 1970, max 49710
  localparam int unsigned RemW      = 6;   // largest divisor is 60
  localparam int unsigned CntW      = 1;   // multiply cycle, then remainder cycle
  localparam int unsigned YoffW     = 8;   // years since 1970, max 136
  localparam int unsigned OutDataW  = 40;  // 36 field bits padded to bytes

  localparam logic [YoffW-1:0] YoffCentLo = 8'd30;   // year 2000
  localparam logic [YoffW-1:0] YoffCentHi = 8'd129;  // year 2099
  localparam logic [YoffW-1:0] YoffNoLeap = 8'd130;  // year 2100, century not leap
  localparam logic [YoffW-1:0] YoffMax    = 8'd136;  // last year a 32-bit time reaches
  localparam logic [DayW-1:0]  WdayOfs    = 16'd4;   // 1970-01-01 was a Thursday
  localparam logic [3:0]       MonFeb     = 4'd2;
  localparam logic [3:0]       MonDec     = 4'd12;
  localparam logic [CntW-1:0]  DivSteps   = 1'b1;    // cycles before the wrap-up

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_YEAR,
    S_MONTH,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_SEC,
    PH_MIN,
    PH_HOUR,
    PH_WDAY
  } phase_e;

  typedef struct packed {
    logic   load;
    logic   div_step;
    logic   div_end;
    phase_e phase;
    logic   year_step;
    logic   month_step;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } sts_t;

  // divisor of each phase
  function automatic logic [RemW-1:0] div_of(input phase_e ph);
    logic [RemW-1:0] d;
    unique case (ph)
      PH_SEC:  d = 6'd60;
      PH_MIN:  d = 6'd60;
      PH_HOUR: d = 6'd24;
      PH_WDAY: d = 6'd7;
      default: d = 6'd60;
    endcase
    return d;
  endfunction

  // reciprocal of each divisor, exact over that phase's dividend range
  function automatic logic [EpochW-1:0] recip_of(input phase_e ph);
    logic [EpochW-1:0] k;
    unique case (ph)
      PH_SEC:  k = 32'h8888_8889;  // 2^37 / 60, rounded up
      PH_MIN:  k = 32'h8888_8889;
      PH_HOUR: k = 32'hAAAA_AAAB;  // 2^36 / 24, rounded up
      PH_WDAY: k = 32'd74899;      // 2^19 / 7, rounded up, 16-bit dividend
      default: k = 32'h8888_8889;
    endcase
    return k;
  endfunction

  // Gregorian leap rule over 1970..2106: only century in range that is not
  // leap is 2100 (2000 is a multiple of 400)
  function automatic logic is_leap_off(input logic [YoffW-1:0] yoff);
    return (yoff[1:0] == 2'd2) && (yoff != YoffNoLeap);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] l;
    unique case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     l = 5'd30;
      4'd2:                                        l = 5'd28;
      default:                                     l = 5'd0;
    endcase
    return l;
  endfunction

endpackage

// File: rtl/epoch_to_calendar_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_to_calendar_top: Unix time to Gregorian calendar fields
// 32-bit seconds since 1970-01-01 UTC in, time of day, weekday, date and
// year within 2000..2099 (with out-of-range flag) out.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents
//  --------  ---  ---------------------------------------------------------
//  s_axis    in   tdata[31:0] epoch_seconds
//  m_axis    out  tdata: sec, min, hour, weekday, day, month, year; tuser: oor
//
//  One beat passes through the shared divider (per phase a reciprocal
//  multiply step and a remainder step), a year walk step per year since
//  1970 plus a final check, a month walk step per month passed plus a final
//  check, a result load and an idle state in which the next beat is taken.
//  Reset clears only the controller and the output valid flag.
//  s_axis_tready_o is high only while the datapath is idle. A finished result
//  sits in the output register; the next beat is taken while it waits, and
//  the controller holds its next result back until m_axis takes the first.
//
module epoch_to_calendar_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [edc_pkg::EpochW-1:0]    s_axis_tdata_i,   // [31:0] epoch_seconds
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
  // [19:17] day_of_week, [24:20] day_of_month, [28:25] month_number,
  // [35:29] year_in_century, [39:36] zero
  output logic [edc_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic                          m_axis_tuser_o    // [0] out_of_range
);
  import edc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  edc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  edc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .epoch_i    (s_axis_tdata_i),
    .out_data_o (m_axis_tdata_o),
    .out_oor_o  (m_axis_tuser_o)
  );

endmodule

// File: rtl/edc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edc_ctrl: conversion sequencer
// Steps the shared divider through its phases, then the year and month walks,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module edc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  edc_pkg::sts_t sts_i,
  output edc_pkg::cmd_t cmd_o
);
  import edc_pkg::*;

  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovalid_q, ovalid_d;
  logic            out_free;

  assign out_free = !ovalid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DIV;
          phase_d = PH_SEC;
          cnt_d   = DivSteps;
        end
      end
      S_DIV: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end else begin
          unique case (phase_q)
            PH_SEC:  phase_d = PH_MIN;
            PH_MIN:  phase_d = PH_HOUR;
            PH_HOUR: phase_d = PH_WDAY;
            PH_WDAY: phase_d = PH_WDAY;
            default: phase_d = PH_SEC;
          endcase
          cnt_d = DivSteps;
          if (phase_q == PH_WDAY) state_d = S_YEAR;
        end
      end
      S_YEAR:  if (sts_i.year_done) state_d = S_MONTH;
      S_MONTH: if (sts_i.month_done) state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.phase = phase_q;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_DIV: begin
        cmd_o.div_step = (cnt_q != '0);
        cmd_o.div_end  = (cnt_q == '0);
      end
      S_YEAR:  cmd_o.year_step  = !sts_i.year_done;
      S_MONTH: cmd_o.month_step = !sts_i.month_done;
      S_OUT:   cmd_o.out_load   = out_free;
      default: ;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_o.out_load)   ovalid_d = 1'b1;
    else if (out_ready_i) ovalid_d = 1'b0;
  end

  assign out_valid_o = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_SEC;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!ovalid_q || out_ready_i))
    else $error("result overwritten while held");

  // an accepted beat starts the seconds division
  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DIV && phase_q == PH_SEC
                                     && cnt_q == DivSteps))
    else $error("accept did not start division");

  // a result stays valid until the sink takes it
  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_ready_i) |=> ovalid_q)
    else $error("result dropped before taken");

endmodule

// File: rtl/edc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edc_dp: conversion datapath
// Reciprocal-multiply divider for /60 /60 /24 and mod 7, year and month
// subtract walks, and the output register.
// ----------------------------------------------------------------------------
module edc_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  edc_pkg::cmd_t                   cmd_i,
  output edc_pkg::sts_t                   sts_o,
  input  logic [edc_pkg::EpochW-1:0]      epoch_i,
  output logic [edc_pkg::OutDataW-1:0]    out_data_o,
  output logic                            out_oor_o
);
  import edc_pkg::*;

  logic [EpochW-1:0] work_q;
  logic [EpochW-1:0] quot_q;
  logic [DayW-1:0]   days_q;
  logic [5:0]        sec_q, min_q;
  logic [4:0]        hr_q;
  logic [2:0]        wd_q;
  logic [YoffW-1:0]  yoff_q;
  logic [3:0]        mon_q;

  logic [5:0] o_sec_q, o_min_q;
  logic [4:0] o_hr_q, o_dom_q;
  logic [2:0] o_wd_q;
  logic [3:0] o_mon_q;
  logic [6:0] o_yic_q;
  logic       o_oor_q;

  // divider: quotient by reciprocal multiply, remainder on the next cycle
  logic [2*EpochW-1:0] prod;
  logic [EpochW-1:0]   quot_n;
  logic [EpochW-1:0]   back;
  logic [EpochW-1:0]   diff;
  logic [RemW-1:0]     rem_n;

  // year and month walks
  logic       leap;
  logic [8:0] ylen;
  logic [4:0] mlen;
  logic       oor;

  assign prod = {{EpochW{1'b0}}, work_q} * {{EpochW{1'b0}}, recip_of(cmd_i.phase)};

  always_comb begin
    unique case (cmd_i.phase)
      PH_SEC, PH_MIN: quot_n = {5'd0, prod[63:37]};
      PH_HOUR:        quot_n = {4'd0, prod[63:36]};
      PH_WDAY:        quot_n = prod[50:19];
      default:        quot_n = {5'd0, prod[63:37]};
    endcase
  end

  assign back  = quot_q * {{(EpochW-RemW){1'b0}}, div_of(cmd_i.phase)};
  assign diff  = work_q - back;
  assign rem_n = diff[RemW-1:0];

  assign leap = is_leap_off(yoff_q);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(mon_q) + {4'd0, (mon_q == MonFeb) && leap};
  assign sts_o.year_done  = (days_q < {7'd0, ylen});
  assign sts_o.month_done = (mon_q == MonDec) || (days_q < {11'd0, mlen});
  assign oor = (yoff_q < YoffCentLo) || (yoff_q > YoffCentHi);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q <= epoch_i;
      yoff_q <= '0;
      mon_q  <= 4'd1;
    end
    if (cmd_i.div_step) begin
      quot_q <= quot_n;
    end
    if (cmd_i.div_end) begin
      unique case (cmd_i.phase)
        PH_SEC: begin
          sec_q  <= rem_n;
          work_q <= quot_q;
        end
        PH_MIN: begin
          min_q  <= rem_n;
          work_q <= quot_q;
        end
        PH_HOUR: begin
          hr_q   <= rem_n[4:0];
          days_q <= quot_q[DayW-1:0];
          work_q <= {{(EpochW-DayW){1'b0}}, quot_q[DayW-1:0] + WdayOfs};
        end
        PH_WDAY: wd_q <= rem_n[2:0] + 3'd1;
        default: ;
      endcase
    end
    if (cmd_i.year_step) begin
      days_q <= days_q - {7'd0, ylen};
      yoff_q <= yoff_q + 1'b1;
    end
    if (cmd_i.month_step) begin
      days_q <= days_q - {11'd0, mlen};
      mon_q  <= mon_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      o_sec_q <= sec_q;
      o_min_q <= min_q;
      o_hr_q  <= hr_q;
      o_wd_q  <= wd_q;
      o_dom_q <= days_q[4:0] + 5'd1;
      o_mon_q <= mon_q;
      o_yic_q <= oor ? 7'd0 : 7'(yoff_q - YoffCentLo);
      o_oor_q <= oor;
    end
  end

  assign out_data_o = {4'd0, o_yic_q, o_mon_q, o_dom_q, o_wd_q, o_hr_q, o_min_q, o_sec_q};
  assign out_oor_o  = o_oor_q;

  a_yoff_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.year_step |-> (yoff_q < YoffMax))
    else $error("year walk past 2106");

  a_mon_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.month_step |-> (mon_q >= 4'd1 && mon_q < MonDec))
    else $error("month walk out of range");

  a_month_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (days_q < 16'd31))
    else $error("day of month out of range at output");

endmodule
